### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they expand to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed: invariant");
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/arlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio RMS level meter package
// Widths, register indexes, controller states, command and status types and
// the output lookup functions shared by the level meter modules.
// ----------------------------------------------------------------------------
package arlm_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int CFG_W      = 18;
    localparam int CFG_ADDR_W = 2;
    localparam int LEN_W      = 11;
    localparam int ALPHA_W    = 9;
    localparam int STEP_W     = 18;
    localparam int SUM_W      = 34;
    localparam int FRAC_W     = 16;
    localparam int DQ_W       = SUM_W + FRAC_W;
    localparam int ROOT_W     = DQ_W / 2;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int RMS_W      = 20;
    localparam int LVL_W      = 21;
    localparam int EMA_W      = 30;
    localparam int INT_W      = 3;
    localparam int LEDS_W     = 5;
    localparam int COL_W      = 8;
    localparam int ITER_W     = 6;

    localparam int MAX_WINDOW  = 1024;
    localparam int BAR_LEDS    = 25;
    localparam int LEN_RESET   = 200;
    localparam int ALPHA_RESET = 51;
    localparam int STEP_RESET  = 10486;
    localparam int ALPHA_ONE   = 256;
    localparam int MID_CODE    = 524288;
    localparam int ROUND_HALF  = 128;
    localparam int EMA_SHIFT   = 8;
    localparam int DIV_STEPS   = DQ_W;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int LEVEL_MAX   = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WINDOW_LENGTH   = 2'd0,
        CFG_SMOOTHING_ALPHA = 2'd1,
        CFG_LEVEL_STEP      = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_EMA_A,
        ST_EMA_B,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic div_step;
        logic sqrt_step;
        logic ema_a;
        logic ema_b;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic win_end;
    } stat_t;

    function automatic logic [LEDS_W-1:0] leds_of(input logic [INT_W-1:0] lvl);
        int prod;
        prod = int'(lvl) * BAR_LEDS;
        return LEDS_W'(prod / 4);
    endfunction

    function automatic logic [COL_W-1:0] red_of(input logic [INT_W-1:0] lvl);
        logic [COL_W-1:0] col;
        case (lvl)
            3'd2:    col = 8'd80;
            3'd3:    col = 8'd120;
            3'd4:    col = 8'd120;
            default: col = 8'd0;
        endcase
        return col;
    endfunction

    function automatic logic [COL_W-1:0] green_of(input logic [INT_W-1:0] lvl);
        logic [COL_W-1:0] col;
        case (lvl)
            3'd1:    col = 8'd80;
            3'd2:    col = 8'd80;
            3'd3:    col = 8'd60;
            default: col = 8'd0;
        endcase
        return col;
    endfunction

endpackage

### hw/rtl/arlm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter datapath
// Configuration registers, square accumulator, bit-serial divider, digit-by-
// digit square root, moving average and output register.
// ----------------------------------------------------------------------------
module arlm_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [arlm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [arlm_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [arlm_pkg::SAMPLE_W-1:0]      s_sample,
    input  arlm_pkg::cmd_t                     cmd,
    output arlm_pkg::stat_t                    stat,
    output logic [arlm_pkg::INT_W-1:0]         m_intensity,
    output logic [arlm_pkg::LEDS_W-1:0]        m_leds_lit,
    output logic [arlm_pkg::COL_W-1:0]         m_red,
    output logic [arlm_pkg::COL_W-1:0]         m_green,
    output logic [arlm_pkg::COL_W-1:0]         m_blue,
    output logic [arlm_pkg::RMS_W-1:0]         m_rms_level,
    output logic [arlm_pkg::LVL_W-1:0]         m_smoothed_level
);
    import arlm_pkg::*;

    logic [LEN_W-1:0]    len_cfg_reg;
    logic [ALPHA_W-1:0]  alpha_cfg_reg;
    logic [STEP_W-1:0]   step_cfg_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [LEN_W-1:0]    count_reg;
    logic [LVL_W-1:0]    smoothed_reg;
    logic [LEN_W-1:0]    div_d_reg;
    logic [LEN_W-1:0]    div_rem_reg;
    logic [DQ_W-1:0]     dq_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SREM_W-1:0]   srem_reg;
    logic [RMS_W-1:0]    rms_reg;
    logic [EMA_W-1:0]    ema_reg;
    logic [INT_W-1:0]    int_out_reg;
    logic [LEDS_W-1:0]   leds_out_reg;
    logic [COL_W-1:0]    red_out_reg;
    logic [COL_W-1:0]    green_out_reg;
    logic [RMS_W-1:0]    rms_out_reg;
    logic [LVL_W-1:0]    lvl_out_reg;

    logic [LEN_W-1:0]       len_eff;
    logic [ALPHA_W-1:0]     alpha_eff;
    logic [ALPHA_W-1:0]     beta;
    logic [2*SAMPLE_W-1:0]  square;
    logic [SUM_W-1:0]       sum_add;
    logic [LEN_W:0]         div_trial;
    logic                   div_ge;
    logic [SREM_W+1:0]      sq_shift;
    logic [SREM_W+1:0]      sq_trial;
    logic                   sq_ge;
    logic [RMS_W-1:0]       rms_sat;
    logic [RMS_W-1:0]       mag_half;
    logic [LVL_W-1:0]       mag;
    logic [EMA_W-1:0]       ema_sum;
    logic [LVL_W-1:0]       thr1;
    logic [LVL_W-1:0]       thr2;
    logic [LVL_W-1:0]       thr3;
    logic [LVL_W-1:0]       thr4;
    logic [INT_W-1:0]       level;

    always_comb begin
        if (len_cfg_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(len_cfg_reg) > MAX_WINDOW) begin
            len_eff = LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = len_cfg_reg;
        end
        alpha_eff = (32'(alpha_cfg_reg) > ALPHA_ONE) ? ALPHA_W'(ALPHA_ONE) : alpha_cfg_reg;
        beta      = ALPHA_W'(ALPHA_ONE) - alpha_eff;
    end

    assign square       = s_sample * s_sample;
    assign sum_add      = sum_reg + SUM_W'(square);
    assign stat.win_end = ({1'b0, count_reg} + (LEN_W+1)'(1)) >= {1'b0, len_eff};

    assign div_trial = {div_rem_reg, dq_reg[DQ_W-1]};
    assign div_ge    = div_trial >= {1'b0, div_d_reg};

    assign sq_shift = {srem_reg, dq_reg[DQ_W-1:DQ_W-2]};
    assign sq_trial = (SREM_W+2)'({root_reg, 2'b01});
    assign sq_ge    = sq_shift >= sq_trial;

    always_comb begin
        if (root_reg[ROOT_W-1:RMS_W] != '0) begin
            rms_sat = '1;
        end else begin
            rms_sat = root_reg[RMS_W-1:0];
        end
        if (rms_sat[RMS_W-1]) begin
            mag_half = rms_sat - RMS_W'(MID_CODE);
        end else begin
            mag_half = RMS_W'(MID_CODE) - rms_sat;
        end
        mag = {mag_half, 1'b0};
    end

    assign ema_sum = ema_reg + EMA_W'(beta * smoothed_reg);

    always_comb begin
        thr1  = LVL_W'(step_cfg_reg);
        thr2  = LVL_W'({step_cfg_reg, 1'b0});
        thr4  = LVL_W'({step_cfg_reg, 2'b00});
        thr3  = thr1 + thr2;
        level = INT_W'(smoothed_reg > thr1) + INT_W'(smoothed_reg > thr2)
              + INT_W'(smoothed_reg > thr3) + INT_W'(smoothed_reg > thr4);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg   <= LEN_W'(LEN_RESET);
            alpha_cfg_reg <= ALPHA_W'(ALPHA_RESET);
            step_cfg_reg  <= STEP_W'(STEP_RESET);
            sum_reg       <= '0;
            count_reg     <= '0;
            smoothed_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_WINDOW_LENGTH:   len_cfg_reg   <= cfg_wdata[LEN_W-1:0];
                    CFG_SMOOTHING_ALPHA: alpha_cfg_reg <= cfg_wdata[ALPHA_W-1:0];
                    CFG_LEVEL_STEP:      step_cfg_reg  <= cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.acc_en) begin
                if (stat.win_end) begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end else begin
                    sum_reg   <= sum_add;
                    count_reg <= count_reg + LEN_W'(1);
                end
            end
            if (cmd.ema_b) begin
                smoothed_reg <= ema_sum[EMA_SHIFT+LVL_W-1:EMA_SHIFT];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_en && stat.win_end) begin
            dq_reg      <= {sum_add, FRAC_W'(0)};
            div_d_reg   <= len_eff;
            div_rem_reg <= '0;
            root_reg    <= '0;
            srem_reg    <= '0;
        end else if (cmd.div_step) begin
            dq_reg      <= {dq_reg[DQ_W-2:0], div_ge};
            div_rem_reg <= div_ge ? LEN_W'(div_trial - {1'b0, div_d_reg})
                                  : div_trial[LEN_W-1:0];
        end else if (cmd.sqrt_step) begin
            dq_reg   <= {dq_reg[DQ_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
            srem_reg <= sq_ge ? SREM_W'(sq_shift - sq_trial) : sq_shift[SREM_W-1:0];
        end
        if (cmd.ema_a) begin
            rms_reg <= rms_sat;
            ema_reg <= EMA_W'(alpha_eff * mag) + EMA_W'(ROUND_HALF);
        end
        if (cmd.out_load) begin
            int_out_reg   <= level;
            leds_out_reg  <= leds_of(level);
            red_out_reg   <= red_of(level);
            green_out_reg <= green_of(level);
            rms_out_reg   <= rms_reg;
            lvl_out_reg   <= smoothed_reg;
        end
    end

    assign m_intensity      = int_out_reg;
    assign m_leds_lit       = leds_out_reg;
    assign m_red            = red_out_reg;
    assign m_green          = green_out_reg;
    assign m_blue           = '0;
    assign m_rms_level      = rms_out_reg;
    assign m_smoothed_level = lvl_out_reg;

endmodule

### hw/rtl/arlm_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Level meter controller
// Sequences sample accumulation, the window-end divide, square root and
// moving average, and holds the result valid flag.
// ----------------------------------------------------------------------------
module arlm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  arlm_pkg::stat_t  stat,
    output arlm_pkg::cmd_t   cmd
);
    import arlm_pkg::*;

    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DIV_STEPS - 1);
    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SQRT_STEPS - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [ITER_W-1:0]  cnt_reg;
    logic [ITER_W-1:0]  cnt_next;
    logic               m_valid_reg;
    logic               m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
                if (s_valid && stat.win_end) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + ITER_W'(1);
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == SQRT_LAST) begin
                    state_next = ST_EMA_A;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + ITER_W'(1);
                end
            end
            ST_EMA_A: begin
                cmd.ema_a  = 1'b1;
                state_next = ST_EMA_B;
            end
            ST_EMA_B: begin
                cmd.ema_b  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_NEXT(a_window_end_starts_div, aclk, aresetn,
                 s_valid && s_ready && stat.win_end, state_reg == ST_DIV)
    `ASSERT_SAME(a_no_result_overwrite, aclk, aresetn,
                 cmd.out_load, !m_valid_reg || m_ready)
    `ASSERT_ALWAYS(a_iter_bounded, aclk, aresetn,
                   (state_reg != ST_DIV || cnt_reg <= DIV_LAST)
                   && (state_reg != ST_SQRT || cnt_reg <= SQRT_LAST))

endmodule

### hw/rtl/audio_rms_level_meter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio RMS level meter core
// Windowed RMS of 12-bit ADC samples, smoothed by a moving average and
// quantised to a five-step loudness level with bar length and colour.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the s_ channel, one transaction per cycle while s_ready is
// high. Each sample's square is added to a 34-bit accumulator. The sample that
// closes a window starts the window-end sequence: a bit-serial divide by the
// window length, a two-bits-per-cycle square root and the moving-average
// multiply steps EMA_A and EMA_B, followed by the output load. s_ready is low
// through that whole sequence, and longer while the load waits on m_ready, so
// no new sample is taken until the result is in the output register.
// One result transaction appears on the m_ channel per window, once the
// window-end sequence has loaded it. The result sits in an output register, so
// sampling carries on while it waits; if m_ready stays low until the next
// window closes, the block holds in the load step until the old result goes.
// Configuration writes take effect at once. The user must make them only
// while the block is idle; the block itself does not enforce this. Reset
// restores the default window of 200 samples, alpha 51/256 and a step of
// 10486, and clears the accumulator, count and smoothed level.
// ----------------------------------------------------------------------------
module audio_rms_level_meter_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [arlm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [arlm_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [arlm_pkg::SAMPLE_W-1:0]      s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [arlm_pkg::INT_W-1:0]         m_intensity,
    output logic [arlm_pkg::LEDS_W-1:0]        m_leds_lit,
    output logic [arlm_pkg::COL_W-1:0]         m_red,
    output logic [arlm_pkg::COL_W-1:0]         m_green,
    output logic [arlm_pkg::COL_W-1:0]         m_blue,
    output logic [arlm_pkg::RMS_W-1:0]         m_rms_level,
    output logic [arlm_pkg::LVL_W-1:0]         m_smoothed_level
);
    import arlm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    arlm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    arlm_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_sample         (s_sample),
        .cmd              (cmd),
        .stat             (stat),
        .m_intensity      (m_intensity),
        .m_leds_lit       (m_leds_lit),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_rms_level      (m_rms_level),
        .m_smoothed_level (m_smoothed_level)
    );

endmodule
